/* hdl/udiv_pkg.sv */
// Shared types and constants for the unsigned 128-by-64 divider.
// Used by udiv_step and unsigned_divide_128_by_64; depends on nothing.
package udiv_pkg;

    // Width of every data port of the top-level divider, and the default operand width.
    localparam int FIELD_W   = 64;
    localparam int DEF_WIDTH = 64;

    // Status codes carried with each item.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // Control bits that travel down the chain beside the data.
    typedef struct packed {
        logic       valid;
        logic [1:0] status;
    } udiv_ctl_t;

endpackage

/* hdl/udiv_step.sv */
// One restoring shift-and-subtract step with its pipeline register.
// Depends on udiv_pkg for the control struct.
module udiv_step #(
    parameter int WIDTH = udiv_pkg::DEF_WIDTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  udiv_pkg::udiv_ctl_t  ctl_in,
    input  logic [WIDTH-1:0]     r_in,
    input  logic [WIDTH-1:0]     q_in,
    input  logic [WIDTH-1:0]     d_in,
    output udiv_pkg::udiv_ctl_t  ctl_out,
    output logic [WIDTH-1:0]     r_out,
    output logic [WIDTH-1:0]     q_out,
    output logic [WIDTH-1:0]     d_out
);

    udiv_pkg::udiv_ctl_t ctl_reg;
    logic [WIDTH-1:0]    r_reg;
    logic [WIDTH-1:0]    q_reg;
    logic [WIDTH-1:0]    d_reg;
    logic [WIDTH-1:0]    r_next;
    logic [WIDTH-1:0]    q_next;
    logic [WIDTH-1:0]    r_shift;
    logic                extra;
    logic                take;

    // Shift R:Q left; the bit leaving R counts as an extra top bit.
    always_comb
    begin
        extra   = r_in[WIDTH-1];
        r_shift = {r_in[WIDTH-2:0], q_in[WIDTH-1]};
        take    = extra || (r_shift >= d_in);
        r_next  = take ? (r_shift - d_in) : r_shift;
        q_next  = {q_in[WIDTH-2:0], take};
    end

    // Control register; cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    // Data registers; no reset needed.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg <= r_next;
            q_reg <= q_next;
            d_reg <= d_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign r_out   = r_reg;
    assign q_out   = q_reg;
    assign d_out   = d_reg;

endmodule

/* hdl/unsigned_divide_128_by_64.sv */
// Unsigned restoring divider, 2*WIDTH-bit dividend by WIDTH-bit divisor.
// Each item passes through the chain of WIDTH step registers, from input accept to result valid.
// Throughput: one item per cycle while no finished result waits to be taken.
// The whole chain stalls together while a finished result waits to be taken.
// Reset (rst_n, asynchronous, active low) clears all valid bits; no data reset.
// Depends on udiv_pkg and udiv_step.
module unsigned_divide_128_by_64 #(
    parameter int WIDTH = udiv_pkg::DEF_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [udiv_pkg::FIELD_W-1:0]  dividend_high,
    input  logic [udiv_pkg::FIELD_W-1:0]  dividend_low,
    input  logic [udiv_pkg::FIELD_W-1:0]  divisor,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [udiv_pkg::FIELD_W-1:0]  quotient,
    output logic [udiv_pkg::FIELD_W-1:0]  remainder,
    output logic [1:0]                    status
);

    localparam int FW = udiv_pkg::FIELD_W;

    udiv_pkg::udiv_ctl_t ctl_chain [0:WIDTH];
    logic [WIDTH-1:0]    r_chain   [0:WIDTH];
    logic [WIDTH-1:0]    q_chain   [0:WIDTH];
    logic [WIDTH-1:0]    d_chain   [0:WIDTH];
    logic                en;

    // The chain advances unless the last stage holds an untaken result.
    assign en       = !ctl_chain[WIDTH].valid || out_ready;
    assign in_ready = en;

    // Feed the first step; status is decided from the original operands.
    always_comb
    begin
        r_chain[0]          = dividend_high[WIDTH-1:0];
        q_chain[0]          = dividend_low[WIDTH-1:0];
        d_chain[0]          = divisor[WIDTH-1:0];
        ctl_chain[0].valid  = in_valid;
        if (divisor[WIDTH-1:0] == '0)
        begin
            ctl_chain[0].status = udiv_pkg::ST_DIV_ZERO;
        end
        else if (dividend_high[WIDTH-1:0] >= divisor[WIDTH-1:0])
        begin
            ctl_chain[0].status = udiv_pkg::ST_OVERFLOW;
        end
        else
        begin
            ctl_chain[0].status = udiv_pkg::ST_OK;
        end
    end

    // Row of identical steps, one quotient bit each.
    for (genvar i = 0; i < WIDTH; i++)
    begin : g_step
        udiv_step #(
            .WIDTH (WIDTH)
        ) u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ctl_in  (ctl_chain[i]),
            .r_in    (r_chain[i]),
            .q_in    (q_chain[i]),
            .d_in    (d_chain[i]),
            .ctl_out (ctl_chain[i+1]),
            .r_out   (r_chain[i+1]),
            .q_out   (q_chain[i+1]),
            .d_out   (d_chain[i+1])
        );
    end

    // The last step register is the output register.
    assign out_valid = ctl_chain[WIDTH].valid;
    assign status    = ctl_chain[WIDTH].status;
    assign quotient  = FW'(q_chain[WIDTH]);
    assign remainder = FW'(r_chain[WIDTH]);

    // A zero divisor always yields an all-ones quotient.
    a_div_zero_ones: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == udiv_pkg::ST_DIV_ZERO) |-> (&q_chain[WIDTH]))
        else $error("divide by zero did not give an all-ones quotient");

    // A valid result never carries the unused status code.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == udiv_pkg::ST_OK || status == udiv_pkg::ST_DIV_ZERO
                       || status == udiv_pkg::ST_OVERFLOW))
        else $error("unused status code on output");

    // While the output stalls, the chain holds still.
    a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(ctl_chain[1]) && $stable(r_chain[1])))
        else $error("chain moved during an output stall");

    // A result with status OK leaves a remainder below the divisor.
    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == udiv_pkg::ST_OK) |-> (r_chain[WIDTH] < d_chain[WIDTH]))
        else $error("remainder not below divisor");

endmodule
